### hdl/bez_pkg.sv
// Shared constants for the cubic Bezier point evaluator.
// Holds default widths, configuration register indexes and the cell depth.
// No dependencies.
package bez_pkg;

    localparam int DEF_COORD_BITS  = 12;
    localparam int DEF_T_FRAC_BITS = 16;

    // Configuration port: eight registers, addressed by a 3-bit index.
    localparam int NUM_CFG_REGS = 8;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CTRL1_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CTRL1_Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CTRL2_X = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CTRL2_Y = 3'd7;

    // Register stages inside one interpolation cell.
    localparam int CELL_STAGES = 3;

endpackage

### hdl/bez_lerp_cell.sv
// One interpolation cell: moves a toward b by the fraction t, rounded to nearest.
// Three register stages: difference, split multiply, sum and apply.
// No package dependencies.
module bez_lerp_cell #(
    parameter int VAL_BITS = 28,
    parameter int FRAC     = 16
) (
    input  logic              aclk,
    input  logic [VAL_BITS-1:0] a_in,
    input  logic [VAL_BITS-1:0] b_in,
    input  logic [FRAC:0]     t_in,
    output logic [VAL_BITS-1:0] res_out
);

    localparam int T_BITS   = FRAC + 1;
    localparam int LO_BITS  = VAL_BITS / 2;
    localparam int HI_BITS  = VAL_BITS - LO_BITS;
    localparam int PLO_BITS = LO_BITS + T_BITS;
    localparam int PHI_BITS = HI_BITS + T_BITS;
    localparam int SUM_BITS = VAL_BITS + FRAC + 2;

    // Stage 1: direction and magnitude of the step.
    logic [VAL_BITS-1:0] a1_reg, a1_next;
    logic [VAL_BITS-1:0] mag1_reg, mag1_next;
    logic                ge1_reg, ge1_next;
    logic [T_BITS-1:0]   t1_reg;

    // Stage 2: the magnitude times t, as two partial products.
    logic [VAL_BITS-1:0] a2_reg;
    logic                ge2_reg;
    logic [PLO_BITS-1:0] plo2_reg, plo2_next;
    logic [PHI_BITS-1:0] phi2_reg, phi2_next;

    // Stage 3: rounded step applied to a.
    logic [SUM_BITS-1:0] sum3;
    logic [VAL_BITS-1:0] step3;
    logic [VAL_BITS-1:0] res_reg, res_next;

    always_comb begin
        ge1_next  = (b_in >= a_in);
        mag1_next = ge1_next ? (b_in - a_in) : (a_in - b_in);
        a1_next   = a_in;
    end

    always_comb begin
        plo2_next = PLO_BITS'(mag1_reg[LO_BITS-1:0]) * PLO_BITS'(t1_reg);
        phi2_next = PHI_BITS'(mag1_reg[VAL_BITS-1:LO_BITS]) * PHI_BITS'(t1_reg);
    end

    // Since t never exceeds one, the step never exceeds the magnitude and
    // fits in VAL_BITS.
    always_comb begin
        sum3     = SUM_BITS'({phi2_reg, {LO_BITS{1'b0}}})
                 + SUM_BITS'(plo2_reg)
                 + (SUM_BITS'(1) << (FRAC - 1));
        step3    = sum3[FRAC +: VAL_BITS];
        res_next = ge2_reg ? (a2_reg + step3) : (a2_reg - step3);
    end

    always_ff @(posedge aclk) begin
        a1_reg   <= a1_next;
        mag1_reg <= mag1_next;
        ge1_reg  <= ge1_next;
        t1_reg   <= t_in;
        a2_reg   <= a1_reg;
        ge2_reg  <= ge1_reg;
        plo2_reg <= plo2_next;
        phi2_reg <= phi2_next;
        res_reg  <= res_next;
    end

    assign res_out = res_reg;

endmodule

### hdl/bez_axis.sv
// One axis of the evaluator: a row of six interpolation cells in three levels,
// followed by rounding and clamping. Uses bez_pkg and bez_lerp_cell.
module bez_axis
    import bez_pkg::*;
#(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int T_FRAC_BITS = DEF_T_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic [COORD_BITS-1:0] p0,
    input  logic [COORD_BITS-1:0] p1,
    input  logic [COORD_BITS-1:0] p2,
    input  logic [COORD_BITS-1:0] p3,
    input  logic [T_FRAC_BITS:0]  t_in,
    output logic [COORD_BITS-1:0] point_out
);

    localparam int VAL_BITS = COORD_BITS + T_FRAC_BITS;
    localparam int DLY      = 2 * CELL_STAGES;

    logic [VAL_BITS-1:0] s0, s1, s2, s3;
    logic [VAL_BITS-1:0] q0, q1, q2;
    logic [VAL_BITS-1:0] r0, r1;
    logic [VAL_BITS-1:0] v;
    logic [T_FRAC_BITS:0] t_dly_reg [DLY];
    logic [T_FRAC_BITS:0] t_lvl2, t_lvl3;
    logic [VAL_BITS:0]    rnd;
    logic [COORD_BITS:0]  whole;
    logic [COORD_BITS-1:0] point_reg, point_next;

    // Control points scaled to the fixed-point format.
    assign s0 = {p0, {T_FRAC_BITS{1'b0}}};
    assign s1 = {p1, {T_FRAC_BITS{1'b0}}};
    assign s2 = {p2, {T_FRAC_BITS{1'b0}}};
    assign s3 = {p3, {T_FRAC_BITS{1'b0}}};

    // t travels alongside the data so that each level sees its own item's t.
    always_ff @(posedge aclk) begin
        t_dly_reg[0] <= t_in;
        for (int i = 1; i < DLY; i++) begin
            t_dly_reg[i] <= t_dly_reg[i-1];
        end
    end

    assign t_lvl2 = t_dly_reg[CELL_STAGES-1];
    assign t_lvl3 = t_dly_reg[DLY-1];

    bez_lerp_cell #(.VAL_BITS(VAL_BITS), .FRAC(T_FRAC_BITS)) u_q0 (
        .aclk(aclk), .a_in(s0), .b_in(s1), .t_in(t_in), .res_out(q0));
    bez_lerp_cell #(.VAL_BITS(VAL_BITS), .FRAC(T_FRAC_BITS)) u_q1 (
        .aclk(aclk), .a_in(s1), .b_in(s2), .t_in(t_in), .res_out(q1));
    bez_lerp_cell #(.VAL_BITS(VAL_BITS), .FRAC(T_FRAC_BITS)) u_q2 (
        .aclk(aclk), .a_in(s2), .b_in(s3), .t_in(t_in), .res_out(q2));

    bez_lerp_cell #(.VAL_BITS(VAL_BITS), .FRAC(T_FRAC_BITS)) u_r0 (
        .aclk(aclk), .a_in(q0), .b_in(q1), .t_in(t_lvl2), .res_out(r0));
    bez_lerp_cell #(.VAL_BITS(VAL_BITS), .FRAC(T_FRAC_BITS)) u_r1 (
        .aclk(aclk), .a_in(q1), .b_in(q2), .t_in(t_lvl2), .res_out(r1));

    bez_lerp_cell #(.VAL_BITS(VAL_BITS), .FRAC(T_FRAC_BITS)) u_v (
        .aclk(aclk), .a_in(r0), .b_in(r1), .t_in(t_lvl3), .res_out(v));

    // Round half up to an integer, then clamp to the coordinate range.
    always_comb begin
        rnd        = (VAL_BITS+1)'(v) + ((VAL_BITS+1)'(1) << (T_FRAC_BITS - 1));
        whole      = rnd[VAL_BITS:T_FRAC_BITS];
        point_next = whole[COORD_BITS] ? {COORD_BITS{1'b1}} : whole[COORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        point_reg <= point_next;
    end

    assign point_out = point_reg;

endmodule

### hdl/cubic_bezier_point_evaluator.sv
// Cubic Bezier point evaluator, de Casteljau construction in fixed point.
// Path to m_: input register, three cell levels, rounding register, queue.
// Throughput: one item per cycle while s_ready is high; a 13-entry output
// queue absorbs stalls. Reset (aresetn, synchronous, active low) zeroes the
// points and empties the pipeline and the queue. Uses bez_pkg and bez_axis.
module cubic_bezier_point_evaluator
    import bez_pkg::*;
#(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int T_FRAC_BITS = DEF_T_FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [T_FRAC_BITS:0]    s_t_fraction,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [COORD_BITS-1:0]   m_point_x,
    output logic [COORD_BITS-1:0]   m_point_y
);

    // The pipeline is an input register, three levels of interpolation cells
    // and a rounding register. It never stalls: every cycle each cell hands
    // its result to the next level. Backpressure is handled by counting the
    // items in flight and in the output queue, and accepting a new item only
    // while the queue is sure to have room for it when it comes out.
    localparam int PIPE_STAGES = 2 + 3 * CELL_STAGES;
    localparam int FIFO_DEPTH  = PIPE_STAGES + 2;
    localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS    = $clog2(FIFO_DEPTH + 1);

    // Configuration registers.
    logic [COORD_BITS-1:0] cfg_reg [NUM_CFG_REGS];

    // Input stage: t saturated to one.
    logic [T_FRAC_BITS:0] t_reg, t_next;

    // Valid bit of each pipeline stage.
    logic [PIPE_STAGES-1:0] vld_reg, vld_next;

    logic [COORD_BITS-1:0] px, py;

    // Output queue.
    logic [COORD_BITS-1:0] fifo_x [FIFO_DEPTH];
    logic [COORD_BITS-1:0] fifo_y [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [CNT_BITS-1:0]   occ_reg, occ_next;

    logic s_acc, m_acc, fifo_wr;

    assign s_ready = (occ_reg < CNT_BITS'(FIFO_DEPTH));
    assign s_acc   = s_valid & s_ready;
    assign m_valid = (fifo_cnt_reg != '0);
    assign m_acc   = m_valid & m_ready;
    assign fifo_wr = vld_reg[PIPE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // A t above one is taken as exactly one, giving the end point.
    always_comb begin
        if (s_t_fraction[T_FRAC_BITS] && (s_t_fraction[T_FRAC_BITS-1:0] != '0)) begin
            t_next = {1'b1, {T_FRAC_BITS{1'b0}}};
        end else begin
            t_next = s_t_fraction;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg <= t_next;
    end

    bez_axis #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_axis_x (
        .aclk     (aclk),
        .p0       (cfg_reg[REG_START_X]),
        .p1       (cfg_reg[REG_CTRL1_X]),
        .p2       (cfg_reg[REG_CTRL2_X]),
        .p3       (cfg_reg[REG_END_X]),
        .t_in     (t_reg),
        .point_out(px)
    );

    bez_axis #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS)) u_axis_y (
        .aclk     (aclk),
        .p0       (cfg_reg[REG_START_Y]),
        .p1       (cfg_reg[REG_CTRL1_Y]),
        .p2       (cfg_reg[REG_CTRL2_Y]),
        .p3       (cfg_reg[REG_END_Y]),
        .t_in     (t_reg),
        .point_out(py)
    );

    always_comb begin
        vld_next = {vld_reg[PIPE_STAGES-2:0], s_acc};
    end

    // Queue pointers wrap at the queue depth, which need not be a power of two.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (fifo_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_BITS'(1);
        end
        if (m_acc) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_BITS'(1);
        end
        fifo_cnt_next = fifo_cnt_reg + CNT_BITS'(fifo_wr) - CNT_BITS'(m_acc);
        occ_next      = occ_reg + CNT_BITS'(s_acc) - CNT_BITS'(m_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            occ_reg      <= '0;
        end else begin
            vld_reg      <= vld_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
            occ_reg      <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fifo_wr) begin
            fifo_x[wr_ptr_reg] <= px;
            fifo_y[wr_ptr_reg] <= py;
        end
    end

    assign m_point_x = fifo_x[rd_ptr_reg];
    assign m_point_y = fifo_y[rd_ptr_reg];

endmodule

### tb/tb_cubic_bezier_point_evaluator.sv
`timescale 1ns / 100ps
// Self-checking testbench for cubic_bezier_point_evaluator: drives curve parameters,
// predicts each curve point in fixed point and checks the results in order.
// Depends on bez_pkg and the evaluator RTL.
module tb_cubic_bezier_point_evaluator;
    import bez_pkg::*;

    localparam int CB = DEF_COORD_BITS;
    localparam int TF = DEF_T_FRAC_BITS;
    localparam int TW = TF + 1;
    localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};
    localparam logic [TF:0] T_HALF = TW'(1) << (TF - 1);
    localparam logic [TF:0] T_TOP = {(TF + 1){1'b1}};
    localparam logic [CB-1:0] C_MAX = {CB{1'b1}};
    localparam int STALL_LIMIT = 5000;
    // The tail wait leaves a generous margin for items still in the pipeline.
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [TF:0]   t;
        logic [CB-1:0] x;
        logic [CB-1:0] y;
    } curve_point_t;

    // Keeps a copy of the control points, predicts the point for each accepted
    // item and compares the returned points in order.
    class curve_point_tracker;
        logic [CB-1:0] points[NUM_CFG_REGS];
        curve_point_t  expected_points[$];
        int            mismatches;

        function new();
            foreach (points[i]) points[i] = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] value);
            points[idx] = value;
        endfunction

        // One interpolation step from a toward b; the step magnitude is rounded
        // to nearest with ties away from zero, so the value stays between a and b.
        function logic [63:0] lerp_step(logic [63:0] a, logic [63:0] b, logic [TF:0] t);
            logic [63:0] span;
            logic [63:0] step;
            span = (b >= a) ? b - a : a - b;
            step = (span * 64'(t) + 64'(T_HALF)) >> TF;
            return (b >= a) ? a + step : a - step;
        endfunction

        function logic [CB-1:0] bezier_axis(logic [CB-1:0] p0, logic [CB-1:0] p1,
                                            logic [CB-1:0] p2, logic [CB-1:0] p3,
                                            logic [TF:0] t);
            logic [63:0] q0, q1, q2, r0, r1, v, rounded;
            q0 = lerp_step(64'(p0) << TF, 64'(p1) << TF, t);
            q1 = lerp_step(64'(p1) << TF, 64'(p2) << TF, t);
            q2 = lerp_step(64'(p2) << TF, 64'(p3) << TF, t);
            r0 = lerp_step(q0, q1, t);
            r1 = lerp_step(q1, q2, t);
            v = lerp_step(r0, r1, t);
            rounded = (v + 64'(T_HALF)) >> TF;
            return (rounded > 64'(C_MAX)) ? C_MAX : rounded[CB-1:0];
        endfunction

        function void note_item(logic [TF:0] t_in);
            curve_point_t p;
            logic [TF:0] t;
            t = (t_in > T_ONE) ? T_ONE : t_in;
            p.t = t_in;
            p.x = bezier_axis(points[REG_START_X], points[REG_CTRL1_X],
                              points[REG_CTRL2_X], points[REG_END_X], t);
            p.y = bezier_axis(points[REG_START_Y], points[REG_CTRL1_Y],
                              points[REG_CTRL2_Y], points[REG_END_Y], t);
            expected_points.push_back(p);
        endfunction

        function void check_point(logic [CB-1:0] x, logic [CB-1:0] y);
            curve_point_t p;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected point (%0d,%0d)", $time, x, y);
                return;
            end
            p = expected_points.pop_front();
            if (x !== p.x || y !== p.y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: point mismatch for t=%0d: expected (%0d,%0d) got (%0d,%0d)",
                             $time, p.t, p.x, p.y, x, y);
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CB-1:0]           cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [TF:0]             s_t_fraction;
    logic                    m_valid;
    logic                    m_ready;
    logic [CB-1:0]           m_point_x;
    logic [CB-1:0]           m_point_y;

    curve_point_tracker book;
    // When set, neither side inserts gaps, so the pipeline runs at full rate.
    bit   no_gaps;
    int   idle_cycles = 0;
    logic [TF:0] directed_t[$];

    cubic_bezier_point_evaluator u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_t_fraction(s_t_fraction),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_point_x   (m_point_x),
        .m_point_y   (m_point_y)
    );

    always #6 aclk = ~aclk;

    // Gap length in cycles: mostly none or a few, now and then a long one.
    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Most parameters lie in [0, 1]; some hit the ends exactly and some go
    // above one, where the block saturates t to one.
    function automatic logic [TF:0] pick_t();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 8) return T_ONE;
        if (r < 25) return TW'($urandom_range(0, int'(T_TOP)));
        return TW'($urandom_range(0, int'(T_ONE)));
    endfunction

    function automatic logic [CB-1:0] pick_coord(int mode);
        case (mode)
            0: begin
                return CB'($urandom_range(0, int'(C_MAX)));
            end
            1: begin
                return $urandom_range(0, 1) ? C_MAX : '0;
            end
            default: begin
                return CB'($urandom_range(0, 7));
            end
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        book.set_reg(idx, value);
    endtask

    // Loads all four points; called only while the block holds no items.
    task automatic load_curve(logic [CB-1:0] sx, logic [CB-1:0] sy,
                              logic [CB-1:0] c1x, logic [CB-1:0] c1y,
                              logic [CB-1:0] c2x, logic [CB-1:0] c2y,
                              logic [CB-1:0] ex, logic [CB-1:0] ey);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_CTRL1_X, c1x);
        write_reg(REG_CTRL1_Y, c1y);
        write_reg(REG_CTRL2_X, c2x);
        write_reg(REG_CTRL2_Y, c2y);
        write_reg(REG_END_X, ex);
        write_reg(REG_END_Y, ey);
        cfg_wr_en <= 1'b0;
    endtask

    // Presents one item after an optional gap and waits for its acceptance.
    // Valid stays high afterwards so that back-to-back items need no toggle.
    task automatic send_item(logic [TF:0] t);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_t_fraction <= t;
        do @(posedge aclk); while (!s_ready);
        book.note_item(t);
    endtask

    // Drops valid and waits until every predicted point has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (book.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_items(int count);
        repeat (count) send_item(pick_t());
        drain();
    endtask

    // The result side stalls at random, with the same gap profile as the sender.
    initial begin
        int stall;
        m_ready <= 1'b0;
        forever begin
            stall = gap_len();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready)
            book.check_point(m_point_x, m_point_y);
    end

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int mode;
        book = new();
        no_gaps = 1'b0;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_t_fraction <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset values: every point at the origin, so both ends give zero.
        send_item('0);
        send_item(T_ONE);
        drain();

        // Corner points, with mixed directions on the x axis; t sweeps the ends,
        // one step from each end, the midpoint, values above one, the quarters and a third.
        load_curve('0, C_MAX, C_MAX, C_MAX, '0, '0, C_MAX, '0);
        directed_t = '{'0, TW'(1), T_HALF, T_ONE - TW'(1), T_ONE, T_ONE + TW'(1), T_TOP,
                       T_ONE >> 2, (T_ONE >> 2) * TW'(3), TW'(21845)};
        foreach (directed_t[i]) send_item(directed_t[i]);
        drain();

        // All points at the top of the coordinate range.
        load_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        directed_t = '{'0, T_HALF, T_ONE, T_TOP};
        foreach (directed_t[i]) send_item(directed_t[i]);
        drain();

        // Unit spans land exactly on half-way ties in the rounding steps.
        load_curve('0, CB'(1), CB'(1), '0, '0, CB'(1), CB'(1), '0);
        directed_t = '{T_HALF, T_ONE >> 2, T_HALF + TW'(1), T_HALF - TW'(1)};
        foreach (directed_t[i]) send_item(directed_t[i]);
        drain();

        // Random part: a new curve for each phase, one phase without any gaps.
        for (int phase = 0; phase < 6; phase++) begin
            mode = phase % 3;
            no_gaps = (phase == 2);
            load_curve(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                       pick_coord(mode), pick_coord(mode), pick_coord(mode),
                       pick_coord(mode), pick_coord(mode));
            random_items(80);
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
